[rtl/wmd_pkg.sv]
// ----------------------------------------------------------------------------
// wmd_pkg: shared types and constants for the waveform min/max decimator
// Holds the request formats of both channels, operation codes, sequencer
// states, the divider handshake and the fixed-point constants of the gain.
// ----------------------------------------------------------------------------
package wmd_pkg;

  // Operation codes of an input request.
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_REBUILD = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Configuration register index (word address).
  localparam logic REG_VISIBLE_COUNT = 1'b0;

  localparam int VIS_W = 13;

  // Gain arithmetic in Q4.12, peak in Q1.15.
  localparam logic [15:0] GAIN_ONE    = 16'd4096;
  localparam logic [15:0] GAIN_MAX    = 16'd40960;
  localparam logic [15:0] PEAK_FLOOR  = 16'd32;
  localparam int          DIV_W       = 27;
  localparam int          DIVISOR_W   = 16;
  localparam logic [26:0] GAIN_NUM    = 27'd110058537;
  localparam logic [26:0] SMOOTH_OLD  = 27'd21;
  localparam logic [26:0] SMOOTH_NEW  = 27'd4;
  localparam logic [26:0] SMOOTH_BIAS = 27'd12;

  // The smoothing divides by 25 as a multiply by ceil(2^26/25) and a shift.
  // This is exact for every weighted sum below 2^26/11, which covers the
  // whole gain range.
  localparam int          SMOOTH_W     = 20;
  localparam int          SMOOTH_SHIFT = 26;
  localparam logic [21:0] SMOOTH_RECIP = 22'd2684355;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] sample;
    logic               last_of_batch;
  } wmd_in_t;

  typedef struct packed {
    logic [5:0]         bin_index;
    logic signed [15:0] bin_min;
    logic [14:0]        bin_max;
    logic [15:0]        display_gain;
    logic               last;
  } wmd_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_ACC,
    ST_TGT,
    ST_TGT_WAIT,
    ST_SMOOTH_GO,
    ST_SMOOTH_WAIT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } wmd_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/waveform_minmax_decimator.sv]
// ----------------------------------------------------------------------------
// waveform_minmax_decimator: min/max peak decimation for one display lane
// Keeps a circular sample history and, on a rebuild, reduces the newest
// samples to BIN_COUNT min/max bins plus a smoothed auto display gain.
// ----------------------------------------------------------------------------
// A plain push, a clear and an ignored op code leave the sequencer idle, so
// samples can stream in back to back at audio rate. A rebuild (op rebuild, or a
// push with last_of_batch set) walks the newest V = min(fill count,
// visible_count) samples through the history RAM's single read port, reading
// each sample and then folding it into its bin, then runs one pass of the
// divider for the peak target (skipped when the peak is at or below the quiet
// threshold), then the smoothing multiply, then for each bin reads the bin RAM
// and hands the bin to the output register, waiting while the consumer stalls.
// A rebuild of an empty history skips the walk and the gain update. While a
// rebuild runs, in_stall is high; the last bin may still sit in the output
// register after the block has become ready again.
// visible_count writes are clamped to the range from BIN_COUNT to the history
// depth (at most 8191) and take effect at the next rebuild.
// ----------------------------------------------------------------------------
module waveform_minmax_decimator #(
  parameter int HISTORY_DEPTH = 4096,
  parameter int BIN_COUNT     = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  wmd_pkg::wmd_in_t  in_request,
  output logic              out_valid,
  input  logic              out_stall,
  output wmd_pkg::wmd_out_t out_request
);
  import wmd_pkg::*;

  // History addressing and counting widths.
  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int FW    = $clog2(HISTORY_DEPTH + 1);
  localparam int CW    = (FW > VIS_W) ? FW : VIS_W;
  localparam int OW    = ((AW > VIS_W) ? AW : VIS_W) + 2;
  // Bin counting and boundary accumulator widths.
  localparam int BW    = $clog2(BIN_COUNT);
  localparam int ACC_W = VIS_W + $clog2(BIN_COUNT + 1) + 1;
  localparam int BIN_DW = 31;
  localparam int SP_W  = SMOOTH_W + 22;

  localparam int VIS_MAX_I   = (HISTORY_DEPTH < 8191) ? HISTORY_DEPTH : 8191;
  localparam int VIS_RESET_I = (HISTORY_DEPTH < 4096) ? HISTORY_DEPTH : 4096;
  localparam logic [VIS_W-1:0] VIS_MAX   = VIS_W'(VIS_MAX_I);
  localparam logic [VIS_W-1:0] VIS_MIN   = VIS_W'(BIN_COUNT);
  localparam logic [VIS_W-1:0] VIS_RESET = VIS_W'(VIS_RESET_I);
  localparam logic [AW-1:0]    WP_LAST   = AW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0]    FILL_FULL = FW'(HISTORY_DEPTH);
  localparam logic [BW-1:0]    BIN_LAST  = BW'(BIN_COUNT - 1);
  localparam logic [ACC_W-1:0] BIN_STEP  = ACC_W'(BIN_COUNT);

  wmd_state_t state, state_next;

  // Control and configuration registers.
  logic [AW-1:0]    wp;
  logic [FW-1:0]    fill;
  logic [15:0]      gain;
  logic [VIS_W-1:0] visible;

  // Rebuild working registers.
  logic [VIS_W-1:0]   vis;
  logic [AW-1:0]      rd_addr;
  logic [ACC_W-1:0]   p_acc;
  logic [ACC_W-1:0]   q_acc;
  logic [BW-1:0]      bin;
  logic signed [15:0] mn;
  logic [14:0]        mx;
  logic [15:0]        peak;
  logic [15:0]        target;
  logic               empty;
  logic [SMOOTH_W-1:0] smooth_sum;

  logic     in_fire;
  logic     push_fire;
  logic     cfg_wr;
  logic     out_load;
  logic     bin_wr;
  logic     bin_cont;
  logic     bin_adv;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [15:0]        hist_rdata;
  logic signed [15:0] v;
  logic signed [15:0] mn_new;
  logic [14:0]        mx_new;
  logic [15:0]        v_abs;
  logic [BIN_DW-1:0]  bin_rdata;
  logic [SP_W-1:0]    smooth_prod;

  logic [VIS_W-1:0] vis_calc;
  logic [CW-1:0]    fill_x;
  logic [CW-1:0]    visible_x;
  logic [OW-1:0]    wp_x;
  logic [OW-1:0]    vis_x;
  logic [OW-1:0]    oldest_x;
  logic [VIS_W-1:0] cfg_val;
  logic [VIS_W-1:0] cfg_clamped;

  // Configuration port: writes complete in the access phase, no wait states.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_VISIBLE_COUNT);
  assign prdata  = (paddr[2] == REG_VISIBLE_COUNT) ? 32'(visible) : 32'd0;
  assign cfg_val = pwdata[VIS_W-1:0];

  always_comb begin
    if (cfg_val < VIS_MIN) begin
      cfg_clamped = VIS_MIN;
    end else if (cfg_val > VIS_MAX) begin
      cfg_clamped = VIS_MAX;
    end else begin
      cfg_clamped = cfg_val;
    end
  end

  // The input side takes a request only while the sequencer is idle.
  assign in_fire   = in_valid && !in_stall;
  assign push_fire = in_fire && (in_request.op == OP_PUSH);

  // Number of visible samples and the history address of the oldest of them.
  assign fill_x    = CW'(fill);
  assign visible_x = CW'(visible);
  assign vis_calc  = VIS_W'((fill_x < visible_x) ? fill_x : visible_x);
  assign wp_x      = OW'(wp);
  assign vis_x     = OW'(vis_calc);

  always_comb begin
    if (wp_x >= vis_x) begin
      oldest_x = wp_x - vis_x;
    end else begin
      oldest_x = wp_x + OW'(HISTORY_DEPTH) - vis_x;
    end
  end

  // Sample from the history RAM and its effect on the running bin extremes.
  assign v     = $signed(hist_rdata);
  assign v_abs = v[15] ? (~hist_rdata + 16'd1) : hist_rdata;

  always_comb begin
    mn_new = (v < mn) ? v : mn;
    mx_new = (v > $signed({1'b0, mx})) ? v[14:0] : mx;
  end

  // Bin boundaries without division: sample s stays in bin b while
  // (s+2)*BIN_COUNT <= (b+1)*V. At the end of a bin the position advances
  // only if (s+1)*BIN_COUNT <= (b+1)*V; otherwise the bin was a single
  // stretched sample and the next bin starts on the same sample.
  assign bin_cont = (p_acc + BIN_STEP) <= q_acc;
  assign bin_adv  = p_acc <= q_acc;

  // Smoothing divide by 25 as a reciprocal multiply on the registered sum.
  assign smooth_prod = SP_W'(smooth_sum) * SP_W'(SMOOTH_RECIP);

  wmd_ram #(
    .WIDTH (16),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (push_fire),
    .wr_addr (wp),
    .wr_data (in_request.sample),
    .rd_addr (rd_addr),
    .rd_data (hist_rdata)
  );

  wmd_ram #(
    .WIDTH (BIN_DW),
    .DEPTH (BIN_COUNT)
  ) u_bin_ram (
    .clk     (clk),
    .wr_en   (bin_wr),
    .wr_addr (bin),
    .wr_data ({mn_new, mx_new}),
    .rd_addr (bin),
    .rd_data (bin_rdata)
  );

  wmd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and the strobes it drives.
  always_comb begin
    state_next       = state;
    in_stall         = (state != ST_IDLE);
    bin_wr           = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = GAIN_NUM + DIV_W'(peak >> 1);
    div_req.divisor  = peak;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_request.op == OP_PUSH && in_request.last_of_batch) ||
              in_request.op == OP_REBUILD) begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        state_next = (fill == '0) ? ST_EMIT_RD : ST_READ;
      end
      ST_READ: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (bin_cont) begin
          state_next = ST_READ;
        end else begin
          bin_wr     = 1'b1;
          state_next = (bin == BIN_LAST) ? ST_TGT : ST_READ;
        end
      end
      ST_TGT: begin
        if (peak > PEAK_FLOOR) begin
          div_req.start = 1'b1;
          state_next    = ST_TGT_WAIT;
        end else begin
          state_next = ST_SMOOTH_GO;
        end
      end
      ST_TGT_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_SMOOTH_GO;
        end
      end
      ST_SMOOTH_GO: begin
        state_next = ST_SMOOTH_WAIT;
      end
      ST_SMOOTH_WAIT: begin
        state_next = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = (bin == BIN_LAST) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // History pointer, fill count, gain and register.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      fill    <= '0;
      gain    <= GAIN_ONE;
      visible <= VIS_RESET;
    end else begin
      if (cfg_wr) begin
        visible <= cfg_clamped;
      end
      if (push_fire) begin
        wp <= (wp == WP_LAST) ? '0 : wp + AW'(1);
        if (fill != FILL_FULL) begin
          fill <= fill + FW'(1);
        end
      end else if (in_fire && in_request.op == OP_CLEAR) begin
        wp   <= '0;
        fill <= '0;
        gain <= GAIN_ONE;
      end
      if (state == ST_SMOOTH_WAIT) begin
        gain <= smooth_prod[SMOOTH_SHIFT +: 16];
      end
    end
  end

  // Rebuild datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_START: begin
        vis     <= vis_calc;
        rd_addr <= oldest_x[AW-1:0];
        p_acc   <= BIN_STEP;
        q_acc   <= ACC_W'(vis_calc);
        bin     <= '0;
        mn      <= '0;
        mx      <= '0;
        peak    <= '0;
        empty   <= (fill == '0);
      end
      ST_ACC: begin
        if (v_abs > peak) begin
          peak <= v_abs;
        end
        if (bin_adv) begin
          rd_addr <= (rd_addr == WP_LAST) ? '0 : rd_addr + AW'(1);
          p_acc   <= p_acc + BIN_STEP;
        end
        if (bin_cont) begin
          mn <= mn_new;
          mx <= mx_new;
        end else begin
          mn    <= '0;
          mx    <= '0;
          q_acc <= q_acc + ACC_W'(vis);
          if (bin == BIN_LAST) begin
            bin <= '0;
          end else begin
            bin <= bin + BW'(1);
          end
        end
      end
      ST_TGT: begin
        target <= GAIN_ONE;
      end
      ST_TGT_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > DIV_W'(GAIN_MAX)) begin
            target <= GAIN_MAX;
          end else if (div_rsp.quotient < DIV_W'(GAIN_ONE)) begin
            target <= GAIN_ONE;
          end else begin
            target <= div_rsp.quotient[15:0];
          end
        end
      end
      ST_SMOOTH_GO: begin
        smooth_sum <= SMOOTH_W'(SMOOTH_OLD * DIV_W'(gain) + SMOOTH_NEW * DIV_W'(target)
                                + SMOOTH_BIAS);
      end
      ST_EMIT_LD: begin
        if (out_load && bin != BIN_LAST) begin
          bin <= bin + BW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: holds one bin until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_request.bin_index    <= 6'(bin);
      out_request.bin_min      <= empty ? 16'sd0 : $signed(bin_rdata[30:15]);
      out_request.bin_max      <= empty ? 15'd0 : bin_rdata[14:0];
      out_request.display_gain <= gain;
      out_request.last         <= (bin == BIN_LAST);
    end
  end

  // A new result only appears after the sequencer loaded it from the bin RAM.
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT_LD))
    else $error("result appeared outside of bin emission");

  // The smoothed gain never leaves its clamp range.
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (gain >= GAIN_ONE) && (gain <= GAIN_MAX))
    else $error("display gain out of range");

  // A plain push leaves the block ready for the next request.
  a_push_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_request.op == OP_PUSH && !in_request.last_of_batch)
    |=> !in_stall)
    else $error("plain push did not complete in one cycle");

  // The last bin of a rebuild always carries bin index BIN_COUNT-1.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_request.last) |-> (out_request.bin_index == 6'(BIN_COUNT - 1)))
    else $error("last flag on wrong bin");

endmodule

[rtl/wmd_ram.sv]
// ----------------------------------------------------------------------------
// wmd_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module wmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/wmd_div.sv]
// ----------------------------------------------------------------------------
// wmd_div: iterative restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module wmd_div (
  input  logic              clk,
  input  logic              rst,
  input  wmd_pkg::div_req_t req,
  output wmd_pkg::div_rsp_t rsp
);
  import wmd_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIV_W-1:0]     dq;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 fits;

  assign rem_sh  = {rem, dq[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign fits    = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (fits) begin
        rem <= rem_sub[DIVISOR_W-1:0];
        dq  <= {dq[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIVISOR_W-1:0];
        dq  <= {dq[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for waveform_minmax_decimator
// Drives push, rebuild, clear and unused requests through the valid/stall
// channel, writes visible_count over the APB-style port while the block is idle,
// and compares every emitted bin with a predictor that keeps its own history,
// fill count and smoothed display gain.
// ----------------------------------------------------------------------------
module tb;
  import wmd_pkg::*;

  localparam int HIST_DEPTH = 4096;
  localparam int NUM_BINS   = 64;
  localparam int IN_W       = $bits(wmd_in_t);

  // Op code 3 has no meaning; the block must swallow it silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Gain arithmetic in Q4.12 with the peak in Q1.15.
  localparam int GAIN_UNITY = 4096;
  localparam int GAIN_CEIL  = 40960;
  localparam int PEAK_QUIET = 32;
  localparam int GAIN_SCALE = 110058537;  // 0.82 in Q4.12 times 2^15

  localparam int VIS_MIN = NUM_BINS;
  localparam int VIS_MAX = HIST_DEPTH;

  // One row of the directed sequence. Where typed is set, every bin of the
  // rebuild carries the listed min, max and gain, which can be read straight
  // off the scenario; all other rows are checked against the predictor.
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] sample;
    logic        mark;
    logic        typed;
    logic [15:0] t_min;
    logic [14:0] t_max;
    logic [15:0] t_gain;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       psel = 1'b0;
  logic       penable = 1'b0;
  logic       pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic       pready;
  logic       in_valid = 1'b0;
  logic       in_stall;
  wmd_in_t    in_request = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  wmd_out_t   out_request;

  // Predictor state: a private copy of the history and the gain.
  logic signed [15:0] hist_mem [HIST_DEPTH];
  int       wr_ptr = 0;
  int       fill_cnt = 0;
  int       gain_q4 = GAIN_UNITY;
  int       vis_cfg = VIS_MAX;
  wmd_out_t bin_calc [NUM_BINS];

  // Bins that the block still owes, oldest first.
  wmd_out_t bins_due [$];
  wmd_out_t due_bin;
  int       mismatches = 0;

  // Idle behavior of the two sides, in percent of cycles.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  dir_row_t dir_rows [0:21] = '{
    // Rebuild right after reset: empty history, all bins zero, gain one.
    '{OP_REBUILD, 16'h0000, 1'b0, 1'b1, 16'h0000, 15'h0000, 16'd4096},
    // The batch mark means nothing on a rebuild.
    '{OP_REBUILD, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 15'h0000, 16'd4096},
    '{OP_UNUSED,  16'h8000, 1'b1, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_CLEAR,   16'h7FFF, 1'b0, 1'b0, 16'h0000, 15'h0000, 16'd0},
    // A single full-scale negative sample fills every bin; the target gain is
    // below one and clamps there.
    '{OP_PUSH,    16'h8000, 1'b1, 1'b1, 16'h8000, 15'h0000, 16'd4096},
    '{OP_PUSH,    16'h7FFF, 1'b1, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_PUSH,    16'h0000, 1'b0, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_UNUSED,  16'h1234, 1'b0, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_CLEAR,   16'h0000, 1'b1, 1'b0, 16'h0000, 15'h0000, 16'd0},
    // A peak under the quiet threshold keeps the gain at one.
    '{OP_PUSH,    16'h0010, 1'b1, 1'b1, 16'h0000, 15'h0010, 16'd4096},
    '{OP_PUSH,    16'hFFE0, 1'b1, 1'b0, 16'h0000, 15'h0000, 16'd0},
    // Just above the threshold the target clamps at the maximum gain.
    '{OP_PUSH,    16'h0021, 1'b1, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_REBUILD, 16'h0000, 1'b0, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_PUSH,    16'h0001, 1'b0, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_PUSH,    16'hFFFE, 1'b0, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_REBUILD, 16'h0000, 1'b0, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_CLEAR,   16'h0000, 1'b0, 1'b0, 16'h0000, 15'h0000, 16'd0},
    // The clear must have brought the raised gain back to one.
    '{OP_REBUILD, 16'h0000, 1'b0, 1'b1, 16'h0000, 15'h0000, 16'd4096},
    '{OP_PUSH,    16'h5555, 1'b0, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_PUSH,    16'hAAAA, 1'b1, 1'b0, 16'h0000, 15'h0000, 16'd0},
    '{OP_CLEAR,   16'h0000, 1'b1, 1'b0, 16'h0000, 15'h0000, 16'd0},
    // An all-zero history has zero peak and leaves the gain at one.
    '{OP_PUSH,    16'h0000, 1'b1, 1'b1, 16'h0000, 15'h0000, 16'd4096}
  };

  waveform_minmax_decimator #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .BIN_COUNT    (NUM_BINS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_request (in_request),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_request(out_request)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Recompute the bins of a rebuild into bin_calc and move the gain on. The
  // visible window is the newest min(fill, visible_count) samples; every bin
  // covers at least one sample, so short histories repeat samples across bins.
  function automatic void rebuild_bins();
    int span, oldest, lo, hi, peak, target, mn, mx, v, b, s;
    span = (fill_cnt < vis_cfg) ? fill_cnt : vis_cfg;
    oldest = (wr_ptr + HIST_DEPTH - span) % HIST_DEPTH;
    peak = 0;
    for (b = 0; b < NUM_BINS; b++) begin
      mn = 0;
      mx = 0;
      if (span != 0) begin
        lo = (b * span) / NUM_BINS;
        hi = ((b + 1) * span) / NUM_BINS;
        if (hi < lo + 1) hi = lo + 1;
        for (s = lo; s < hi; s++) begin
          v = hist_mem[(oldest + s) % HIST_DEPTH];
          if (v < mn) mn = v;
          if (v > mx) mx = v;
        end
      end
      if (-mn > peak) peak = -mn;
      if (mx > peak) peak = mx;
      bin_calc[b].bin_index = 6'(b);
      bin_calc[b].bin_min   = 16'(mn);
      bin_calc[b].bin_max   = 15'(mx);
      bin_calc[b].last      = (b == NUM_BINS - 1);
    end
    // An empty history leaves the gain untouched.
    if (span != 0) begin
      target = GAIN_UNITY;
      if (peak > PEAK_QUIET) begin
        target = (GAIN_SCALE + peak / 2) / peak;
        if (target < GAIN_UNITY) target = GAIN_UNITY;
        if (target > GAIN_CEIL) target = GAIN_CEIL;
      end
      gain_q4 = (21 * gain_q4 + 4 * target + 12) / 25;
    end
    for (b = 0; b < NUM_BINS; b++) bin_calc[b].display_gain = 16'(gain_q4);
  endfunction

  // Apply one accepted request to the predictor; returns the number of bins
  // that it makes the block emit.
  function automatic int apply_request(wmd_in_t r);
    case (r.op)
      OP_PUSH: begin
        hist_mem[wr_ptr] = r.sample;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        if (fill_cnt < HIST_DEPTH) fill_cnt++;
        if (r.last_of_batch) begin
          rebuild_bins();
          return NUM_BINS;
        end
      end
      OP_REBUILD: begin
        rebuild_bins();
        return NUM_BINS;
      end
      OP_CLEAR: begin
        wr_ptr = 0;
        fill_cnt = 0;
        gain_q4 = GAIN_UNITY;
      end
      default: ;
    endcase
    return 0;
  endfunction

  function automatic wmd_in_t make_req(logic [1:0] op, logic [15:0] sample, logic mark);
    wmd_in_t r;
    r.op = op;
    r.sample = sample;
    r.last_of_batch = mark;
    return r;
  endfunction

  // Sample values lean toward the interesting corners: full scale, values near
  // the quiet threshold, and mid-range audio.
  function automatic logic [15:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 80);
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(pick - 40);
      2: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed(16'($urandom)) >>> 3);
    endcase
  endfunction

  // Offer one request and wait until the block takes it. Called at a rising
  // edge; returns at the edge where the request was accepted. Idle cycles in
  // front of the request carry junk payload with valid low.
  task automatic drive_request(input wmd_in_t r, input bit typed = 1'b0,
                               input wmd_out_t pattern = '0);
    int n, b;
    wmd_out_t due;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_request <= wmd_in_t'(IN_W'($urandom));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_request <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = apply_request(r);
    for (b = 0; b < n; b++) begin
      due = bin_calc[b];
      if (typed) begin
        due.bin_min = pattern.bin_min;
        due.bin_max = pattern.bin_max;
        due.display_gain = pattern.display_gain;
      end
      bins_due.push_back(due);
    end
  endtask

  // Hold the request channel quiet until every owed bin has come out, then let
  // the output register empty before touching the register.
  task automatic settle();
    in_valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write: setup cycle, then access cycle. The register
  // clamps the value into [BIN_COUNT, history depth].
  task automatic write_visible(input logic [31:0] value);
    int v;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_VISIBLE_COUNT, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    v = int'(value[12:0]);
    vis_cfg = (v < VIS_MIN) ? VIS_MIN : (v > VIS_MAX) ? VIS_MAX : v;
  endtask

  // Random traffic: mostly batches of pushes closed by the batch mark, with
  // stray pushes, bare rebuilds, clears and unused op codes mixed in. Unused
  // op codes do nothing and are not counted.
  task automatic run_random(input int count);
    int sent, pick, n, i;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
          drive_request(make_req(OP_PUSH, rand_sample(), i == n - 1));
        sent += n;
      end else if (pick < 72) begin
        drive_request(make_req(OP_PUSH, rand_sample(), 1'b0));
        sent++;
      end else if (pick < 84) begin
        drive_request(make_req(OP_REBUILD, 16'($urandom), 1'($urandom)));
        sent++;
      end else if (pick < 92) begin
        drive_request(make_req(OP_CLEAR, 16'($urandom), 1'($urandom)));
        sent++;
      end else begin
        drive_request(make_req(OP_UNUSED, 16'($urandom), 1'($urandom)));
      end
    end
  endtask

  // Output side: check each accepted bin against the oldest owed one and draw
  // the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (bins_due.size() == 0) begin
        $error("bin %0d arrived with no rebuild pending", out_request.bin_index);
        mismatches++;
      end else begin
        due_bin = bins_due.pop_front();
        if (out_request.bin_index !== due_bin.bin_index) begin
          $error("bin_index: expected %0d, got %0d", due_bin.bin_index,
                 out_request.bin_index);
          mismatches++;
        end
        if (out_request.bin_min !== due_bin.bin_min) begin
          $error("bin_min: expected %0d, got %0d", due_bin.bin_min, out_request.bin_min);
          mismatches++;
        end
        if (out_request.bin_max !== due_bin.bin_max) begin
          $error("bin_max: expected %0d, got %0d", due_bin.bin_max, out_request.bin_max);
          mismatches++;
        end
        if (out_request.display_gain !== due_bin.display_gain) begin
          $error("display_gain: expected %0d, got %0d", due_bin.display_gain,
                 out_request.display_gain);
          mismatches++;
        end
        if (out_request.last !== due_bin.last) begin
          $error("last: expected %0d, got %0d", due_bin.last, out_request.last);
          mismatches++;
        end
      end
    end
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Stimulus sequence.
  initial begin
    int i, k;
    dir_row_t row;
    wmd_out_t pattern;
    int send_modes [4];
    int recv_modes [4];
    send_modes = '{0, 80, 0, 35};
    recv_modes = '{0, 0, 80, 35};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the register at its reset value.
    for (i = 0; i < $size(dir_rows); i++) begin
      row = dir_rows[i];
      pattern = '0;
      pattern.bin_min = row.t_min;
      pattern.bin_max = row.t_max;
      pattern.display_gain = row.t_gain;
      drive_request(make_req(row.op, row.sample, row.mark), row.typed, pattern);
    end
    settle();

    // Fill the history with a few more samples than there are bins. An
    // all-ones write clamps to the full depth.
    write_visible(32'h0000_1FFF);
    drive_request(make_req(OP_CLEAR, 16'h0000, 1'b0));
    for (i = 0; i < NUM_BINS + 2; i++)
      drive_request(make_req(OP_PUSH, rand_sample(), 1'b0));
    drive_request(make_req(OP_REBUILD, 16'h0000, 1'b0));
    settle();

    // The smallest window, shorter than the filled history.
    write_visible(32'h0000_0000);
    drive_request(make_req(OP_REBUILD, 16'h0000, 1'b0));
    settle();
    write_visible(32'd63);
    drive_request(make_req(OP_PUSH, rand_sample(), 1'b1));
    settle();

    // A window that does not divide evenly into the bins.
    write_visible(32'd65);
    drive_request(make_req(OP_REBUILD, 16'h0000, 1'b0));
    drive_request(make_req(OP_PUSH, rand_sample(), 1'b1));
    settle();

    // Random phases, each with its own idle pattern and window size. Every
    // phase starts from a drained block, which also makes the sender pause
    // until all owed bins have come out.
    for (k = 0; k < 4; k++) begin
      send_idle_pct = send_modes[k];
      recv_stall_pct = recv_modes[k];
      case (k)
        0: write_visible(32'h0000_1FFF);
        1: write_visible($urandom_range(0, 63));
        2: write_visible($urandom_range(64, 300));
        default: write_visible($urandom_range(64, 1000));
      endcase
      run_random(6);
      settle();
    end

    // Let any stray bin show up before the verdict.
    repeat (20) @(posedge clk);
    if (mismatches == 0 && bins_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
